// ===== sv/erm_pkg.sv =====
// Shared types and constants for the event rate monitor.
package erm_pkg;

    // Rate scaling: events per microsecond to events per second.
    localparam int unsigned SCALE_BITS  = 20;
    localparam int unsigned SCALE_IDX_W = 5;
    localparam logic [SCALE_BITS-1:0] RATE_SCALE = 20'd1000000;

    localparam int unsigned RATE_W = 32;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_ERROR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_WARN  = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] WINDOW_RST     = 32'd1000000;
    localparam logic [CFG_W-1:0] WARN_RATE_RST  = 32'd10;
    localparam logic [CFG_W-1:0] ERROR_RATE_RST = 32'd100;
    localparam logic [CFG_W-1:0] HOLD_ERROR_RST = 32'd10000000;
    localparam logic [CFG_W-1:0] HOLD_WARN_RST  = 32'd30000000;

    // Levels, severities and event kinds.
    localparam logic [1:0] LVL_NORMAL = 2'd0;
    localparam logic [1:0] LVL_WARN   = 2'd1;
    localparam logic [1:0] LVL_ERROR  = 2'd2;

    localparam logic [1:0] SEV_INFO  = 2'd0;
    localparam logic [1:0] SEV_WARN  = 2'd1;
    localparam logic [1:0] SEV_ERROR = 2'd2;

    localparam logic KIND_WARN  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

endpackage

// ===== sv/erm_in_if.sv =====
// Tick channel: current time and cumulative event count.
interface erm_in_if #(
    parameter int unsigned TIME_BITS  = 48,
    parameter int unsigned COUNT_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  now_time_us;
    logic [COUNT_BITS-1:0] event_total;

    modport source (output valid, output now_time_us, output event_total, input ready);
    modport sink   (input valid, input now_time_us, input event_total, output ready);
endinterface

// ===== sv/erm_out_if.sv =====
// Alert channel: one rate event per transaction.
interface erm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  severity;
    logic        event_kind;
    logic [31:0] rate_per_sec;
    logic [1:0]  new_level;

    modport source (output valid, output severity, output event_kind,
                    output rate_per_sec, output new_level, input ready);
    modport sink   (input valid, input severity, input event_kind,
                    input rate_per_sec, input new_level, output ready);
endinterface

// ===== sv/event_rate_monitor_hysteresis.sv =====
// Event rate monitor with hysteresis: top level sequencer and state.
//
// Each tick transaction carries the time in microseconds and a wrapping
// event count. When at least window_us has passed since the last
// evaluation, the rate in events per second is worked out by a serial
// unit with one shared adder: shift-and-add scaling by one million over
// the 20 bits of the scale constant, then one quotient bit per cycle over
// COUNT_BITS + 20 dividend bits. A tick that passes the window holds the
// tick port off through the window check, the scaling, the divide, the
// registered done flag and the decision. A tick inside the window holds
// the port off only for the window check, and no new tick is taken
// before the last one is through. The rate sets the level at once when
// it rises, and only after the hold time of the current level when it
// falls. Rises and the drop to warning produce one alert transaction;
// the tick port stays low on ready while an item is being worked on,
// and an alert waits in an output register until taken. The decision
// cycle waits while an earlier alert is still held there, which
// stretches the busy time by that stall.
module event_rate_monitor_hysteresis
    import erm_pkg::*;
#(
    parameter int unsigned TIME_BITS  = 48,
    parameter int unsigned COUNT_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    erm_in_if.sink               tick,
    erm_out_if.source            alert
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_CALC   = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;

    logic [CFG_W-1:0]      window_reg, warn_rate_reg, error_rate_reg;
    logic [CFG_W-1:0]      hold_error_reg, hold_warn_reg;

    logic [TIME_BITS-1:0]  now_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [TIME_BITS-1:0]  last_eval_reg, last_eval_next;
    logic [COUNT_BITS-1:0] last_total_reg, last_total_next;
    logic [1:0]            level_reg, level_next;
    logic [TIME_BITS-1:0]  stable_reg, stable_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            sev_reg, sev_next;
    logic                  kind_reg, kind_next;
    logic [RATE_W-1:0]     out_rate_reg, out_rate_next;
    logic [1:0]            new_level_reg, new_level_next;

    logic [TIME_BITS-1:0]  elapsed;
    logic [COUNT_BITS-1:0] delta;
    logic                  window_met;
    logic                  md_start, md_done;
    logic [RATE_W-1:0]     md_quot;

    logic [1:0]            desired;
    logic [TIME_BITS-1:0]  stable_eff, dur, dur_idle;
    logic [CFG_W-1:0]      hold_req;
    logic                  accept, out_free;

    assign accept   = tick.valid & tick.ready;
    assign out_free = ~out_valid_reg | alert.ready;

    assign elapsed    = now_reg - last_eval_reg;
    assign delta      = total_reg - last_total_reg;
    assign window_met = elapsed >= {{(TIME_BITS - CFG_W){1'b0}}, window_reg};
    assign md_start   = (state_reg == ST_CHECK) & window_met & (elapsed != '0);

    erm_muldiv #(
        .CNT_W  (COUNT_BITS),
        .TIME_W (TIME_BITS)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .delta    (delta),
        .divisor  (elapsed),
        .done     (md_done),
        .quotient (md_quot)
    );

    // Classification and hold-time arithmetic.
    always_comb
    begin
        if (rate_reg >= error_rate_reg)
            desired = LVL_ERROR;
        else if (rate_reg >= warn_rate_reg)
            desired = LVL_WARN;
        else
            desired = LVL_NORMAL;
        stable_eff = (stable_reg == '0) ? now_reg : stable_reg;
        dur        = now_reg - stable_eff;
        dur_idle   = now_reg - stable_reg;
        hold_req   = (level_reg == LVL_ERROR) ? hold_error_reg : hold_warn_reg;
    end

    // Sequencer and level update.
    always_comb
    begin
        state_next      = state_reg;
        last_eval_next  = last_eval_reg;
        last_total_next = last_total_reg;
        level_next      = level_reg;
        stable_next     = stable_reg;
        rate_next       = rate_reg;
        out_valid_next  = out_valid_reg & ~alert.ready;
        sev_next        = sev_reg;
        kind_next       = kind_reg;
        out_rate_next   = out_rate_reg;
        new_level_next  = new_level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!window_met)
                    state_next = ST_IDLE;
                else if (elapsed == '0)
                begin
                    rate_next  = '0;
                    state_next = ST_DECIDE;
                end
                else
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (md_done)
                begin
                    rate_next  = md_quot;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next      = ST_IDLE;
                    last_eval_next  = now_reg;
                    last_total_next = total_reg;
                    if (desired > level_reg)
                    begin
                        // Rise: take effect now and restart the hold clock.
                        stable_next    = now_reg;
                        level_next     = desired;
                        out_valid_next = 1'b1;
                        sev_next       = (desired == LVL_ERROR) ? SEV_ERROR : SEV_WARN;
                        kind_next      = (desired == LVL_ERROR) ? KIND_ERROR : KIND_WARN;
                        out_rate_next  = rate_reg;
                        new_level_next = desired;
                    end
                    else if (desired != level_reg)
                    begin
                        // Fall: only once the hold time of the current level is met.
                        stable_next = stable_eff;
                        if (dur >= {{(TIME_BITS - CFG_W){1'b0}}, hold_req})
                        begin
                            stable_next = '0;
                            level_next  = desired;
                            if (desired != LVL_NORMAL)
                            begin
                                out_valid_next = 1'b1;
                                sev_next       = SEV_INFO;
                                kind_next      = KIND_WARN;
                                out_rate_next  = rate_reg;
                                new_level_next = desired;
                            end
                        end
                    end
                    else if (desired == LVL_NORMAL && stable_reg != '0)
                    begin
                        // Settled at normal: stop the hold clock once it has run out.
                        if (dur_idle >= {{(TIME_BITS - CFG_W){1'b0}}, hold_error_reg})
                            stable_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_eval_reg  <= '0;
            last_total_reg <= '0;
            level_reg      <= LVL_NORMAL;
            stable_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_eval_reg  <= last_eval_next;
            last_total_reg <= last_total_next;
            level_reg      <= level_next;
            stable_reg     <= stable_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= WINDOW_RST;
            warn_rate_reg  <= WARN_RATE_RST;
            error_rate_reg <= ERROR_RATE_RST;
            hold_error_reg <= HOLD_ERROR_RST;
            hold_warn_reg  <= HOLD_WARN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW:     window_reg     <= cfg_data;
                REG_WARN_RATE:  warn_rate_reg  <= cfg_data;
                REG_ERROR_RATE: error_rate_reg <= cfg_data;
                REG_HOLD_ERROR: hold_error_reg <= cfg_data;
                REG_HOLD_WARN:  hold_warn_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= tick.now_time_us;
            total_reg <= tick.event_total;
        end
        rate_reg      <= rate_next;
        sev_reg       <= sev_next;
        kind_reg      <= kind_next;
        out_rate_reg  <= out_rate_next;
        new_level_reg <= new_level_next;
    end

    assign tick.ready         = (state_reg == ST_IDLE);
    assign alert.valid        = out_valid_reg;
    assign alert.severity     = sev_reg;
    assign alert.event_kind   = kind_reg;
    assign alert.rate_per_sec = out_rate_reg;
    assign alert.new_level    = new_level_reg;

endmodule

// ===== sv/erm_muldiv.sv =====
// Serial scale-and-divide unit: (delta * 1000000) / divisor, saturated to 32 bits.
module erm_muldiv
    import erm_pkg::*;
#(
    parameter int unsigned CNT_W  = 32,
    parameter int unsigned TIME_W = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CNT_W-1:0]  delta,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [RATE_W-1:0] quotient
);

    localparam int unsigned PROD_W = CNT_W + SCALE_BITS;
    localparam int unsigned SUM_W  = (PROD_W > TIME_W + 1) ? PROD_W : TIME_W + 1;
    localparam int unsigned STEP_W = $clog2(PROD_W + 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(SCALE_BITS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0] q_reg, q_next;
    logic              sat_reg, sat_next;
    logic              done_reg, done_next;

    logic [SUM_W:0]    op_a, op_b, sum;
    logic              op_sub;
    logic [TIME_W:0]   rem_shift;
    logic              take;

    // Shared adder/subtractor.
    assign sum = op_sub ? (op_a - op_b) : (op_a + op_b);

    assign rem_shift = {rem_reg, acc_reg[PROD_W-1]};
    assign take      = ~sum[SUM_W];

    // Operand selection: accumulate in the multiply phase, trial subtract in the divide phase.
    always_comb
    begin
        op_a   = {{(SUM_W + 1 - PROD_W){1'b0}}, acc_reg[PROD_W-2:0], 1'b0};
        op_b   = {{(SUM_W + 1 - CNT_W){1'b0}}, delta};
        op_sub = 1'b0;
        if (state_reg == MD_DIV)
        begin
            op_a   = {{(SUM_W - TIME_W){1'b0}}, rem_shift};
            op_b   = {{(SUM_W + 1 - TIME_W){1'b0}}, divisor};
            op_sub = 1'b1;
        end
        else if (!RATE_SCALE[step_reg[SCALE_IDX_W-1:0]])
        begin
            op_b = '0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    state_next = MD_MUL;
                    step_next  = MUL_LAST;
                    acc_next   = '0;
                end
            end
            MD_MUL:
            begin
                acc_next = sum[PROD_W-1:0];
                if (step_reg == '0)
                begin
                    state_next = MD_DIV;
                    step_next  = DIV_LAST;
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            MD_DIV:
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                rem_next = take ? sum[TIME_W-1:0] : rem_shift[TIME_W-1:0];
                q_next   = {q_reg[RATE_W-2:0], take};
                sat_next = sat_reg | q_reg[RATE_W-1];
                if (step_reg == '0)
                begin
                    state_next = MD_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? RATE_MAX : q_reg;

endmodule

// ===== bench/erm_alert_checker.sv =====
// Alert checker: predicts rate alerts from tick transactions and compares them field by field.
`timescale 1ns / 1ps

module erm_alert_checker
    import erm_pkg::*;
#(
    parameter int unsigned TIME_W  = 48,
    parameter int unsigned COUNT_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    erm_in_if                    tick,
    erm_out_if                   alert,
    output int unsigned          mismatch_count,
    output int unsigned          alerts_awaited,
    output int unsigned          alerts_checked
);

    typedef struct packed {
        logic [1:0]        severity;
        logic              event_kind;
        logic [RATE_W-1:0] rate_per_sec;
        logic [1:0]        new_level;
    } rate_alert_t;

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0] window_us;
    logic [CFG_W-1:0] warn_thr;
    logic [CFG_W-1:0] error_thr;
    logic [CFG_W-1:0] hold_error_us;
    logic [CFG_W-1:0] hold_warn_us;

    // Predicted monitor state.
    logic [TIME_W-1:0]  last_eval_us;
    logic [COUNT_W-1:0] last_total;
    logic [1:0]         cur_level;
    logic [TIME_W-1:0]  stable_since_us;

    rate_alert_t awaited_alerts[$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t ns] alert check: %s", $time, msg);
        mismatch_count++;
    endtask

    // Events per second, saturated to the rate width; a zero interval gives zero.
    function automatic logic [RATE_W-1:0] events_per_second(
        input logic [COUNT_W-1:0] delta,
        input logic [TIME_W-1:0]  elapsed
    );
        logic [127:0] scaled;
        logic [127:0] quotient;
        if (elapsed == '0)
            return '0;
        scaled   = 128'(delta) * 128'd1000000;
        quotient = scaled / 128'(elapsed);
        if (quotient > 128'(RATE_MAX))
            return RATE_MAX;
        return quotient[RATE_W-1:0];
    endfunction

    task automatic write_shadow(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_WINDOW:     window_us     = value;
            REG_WARN_RATE:  warn_thr      = value;
            REG_ERROR_RATE: error_thr     = value;
            REG_HOLD_ERROR: hold_error_us = value;
            REG_HOLD_WARN:  hold_warn_us  = value;
            default: ;
        endcase
    endtask

    // Works out the level change caused by one tick and queues any alert it raises.
    task automatic evaluate_rate_tick(
        input logic [TIME_W-1:0]  now_us,
        input logic [COUNT_W-1:0] total
    );
        logic [TIME_W-1:0]  elapsed;
        logic [TIME_W-1:0]  held_for;
        logic [COUNT_W-1:0] delta;
        logic [RATE_W-1:0]  rate;
        logic [CFG_W-1:0]   hold_needed;
        logic [1:0]         target;
        rate_alert_t        raised;

        elapsed = now_us - last_eval_us;
        if (elapsed < TIME_W'(window_us))
            return;

        delta        = total - last_total;
        rate         = events_per_second(delta, elapsed);
        last_total   = total;
        last_eval_us = now_us;

        // The error threshold is tested first, so a warning threshold above it is shadowed.
        if (rate >= error_thr)
            target = LVL_ERROR;
        else if (rate >= warn_thr)
            target = LVL_WARN;
        else
            target = LVL_NORMAL;

        if (target > cur_level)
        begin
            // Rises take effect at once and restart the hold clock.
            stable_since_us     = now_us;
            cur_level           = target;
            raised.severity     = (target == LVL_ERROR) ? SEV_ERROR : SEV_WARN;
            raised.event_kind   = (target == LVL_ERROR) ? KIND_ERROR : KIND_WARN;
            raised.rate_per_sec = rate;
            raised.new_level    = target;
            awaited_alerts.push_back(raised);
        end
        else if (target < cur_level)
        begin
            // Falls wait out the hold time of the level being left.
            if (stable_since_us == '0)
                stable_since_us = now_us;
            held_for    = now_us - stable_since_us;
            hold_needed = (cur_level == LVL_ERROR) ? hold_error_us : hold_warn_us;
            if (held_for >= TIME_W'(hold_needed))
            begin
                stable_since_us = '0;
                cur_level       = target;
                if (target != LVL_NORMAL)
                begin
                    raised.severity     = SEV_INFO;
                    raised.event_kind   = KIND_WARN;
                    raised.rate_per_sec = rate;
                    raised.new_level    = target;
                    awaited_alerts.push_back(raised);
                end
            end
        end
        else if (target == LVL_NORMAL && stable_since_us != '0)
        begin
            held_for = now_us - stable_since_us;
            if (held_for >= TIME_W'(hold_error_us))
                stable_since_us = '0;
        end
    endtask

    // Compares one alert transaction with the oldest prediction.
    task automatic check_alert();
        rate_alert_t want;
        alerts_checked++;
        if (awaited_alerts.size() == 0)
        begin
            report_mismatch($sformatf("unexpected alert, level %0d rate %0d",
                                      alert.new_level, alert.rate_per_sec));
            return;
        end
        want = awaited_alerts.pop_front();
        if (alert.severity !== want.severity)
            report_mismatch($sformatf("severity %0d, expected %0d",
                                      alert.severity, want.severity));
        if (alert.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d",
                                      alert.event_kind, want.event_kind));
        if (alert.rate_per_sec !== want.rate_per_sec)
            report_mismatch($sformatf("rate_per_sec %0d, expected %0d",
                                      alert.rate_per_sec, want.rate_per_sec));
        if (alert.new_level !== want.new_level)
            report_mismatch($sformatf("new_level %0d, expected %0d",
                                      alert.new_level, want.new_level));
    endtask

    // Register writes, tick and alert transactions, all sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_us       = WINDOW_RST;
            warn_thr        = WARN_RATE_RST;
            error_thr       = ERROR_RATE_RST;
            hold_error_us   = HOLD_ERROR_RST;
            hold_warn_us    = HOLD_WARN_RST;
            last_eval_us    = '0;
            last_total      = '0;
            cur_level       = LVL_NORMAL;
            stable_since_us = '0;
            awaited_alerts.delete();
            mismatch_count  = 0;
            alerts_awaited  = 0;
            alerts_checked  = 0;
        end
        else
        begin
            if (cfg_we)
                write_shadow(cfg_index, cfg_data);
            if (tick.valid && tick.ready)
                evaluate_rate_tick(tick.now_time_us, tick.event_total);
            if (alert.valid && alert.ready)
                check_alert();
            alerts_awaited = awaited_alerts.size();
        end
    end

endmodule

// ===== bench/event_rate_monitor_hysteresis_test.sv =====
// Testbench top: clock, reset, tick stimulus, alert back-pressure and the final verdict.
`timescale 1ns / 1ps

module event_rate_monitor_hysteresis_test;
    import erm_pkg::*;

    localparam int unsigned TIME_W          = 48;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned ITEMS_PER_PHASE = 255;
    localparam int unsigned HOLD_OFF_AT     = 8000;
    localparam int unsigned HOLD_OFF_LEN    = 3000;
    localparam int unsigned DRAIN_LIMIT     = 100000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int unsigned mismatch_count;
    int unsigned alerts_awaited;
    int unsigned alerts_checked;

    logic [TIME_W-1:0]  tick_time;
    logic [COUNT_W-1:0] tick_count;
    logic [CFG_W-1:0]   reg_shadow [5];
    int unsigned        ticks_sent;
    int unsigned        settings_used;
    int unsigned        rate_band;
    bit                 gaps_enabled;

    erm_in_if #(.TIME_BITS(TIME_W), .COUNT_BITS(COUNT_W)) tick_ch ();
    erm_out_if alert_ch ();

    event_rate_monitor_hysteresis #(
        .TIME_BITS  (TIME_W),
        .COUNT_BITS (COUNT_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .alert     (alert_ch)
    );

    erm_alert_checker #(
        .TIME_W  (TIME_W),
        .COUNT_W (COUNT_W)
    ) alert_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tick           (tick_ch),
        .alert          (alert_ch),
        .mismatch_count (mismatch_count),
        .alerts_awaited (alerts_awaited),
        .alerts_checked (alerts_checked)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly none or short, occasionally long.
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 4);
        return $urandom_range(15, 120);
    endfunction

    // One register write; the enable drops again on the next falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        @(negedge clk);
        reg_shadow[idx] = value;
    endtask

    // Waits until every predicted alert has arrived and any silent evaluation has finished.
    task automatic wait_idle();
        tick_ch.valid = 1'b0;
        while (alerts_awaited != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic apply_settings(
        input logic [CFG_W-1:0] window,
        input logic [CFG_W-1:0] warn,
        input logic [CFG_W-1:0] err,
        input logic [CFG_W-1:0] hold_err,
        input logic [CFG_W-1:0] hold_warn
    );
        wait_idle();
        write_reg(REG_WINDOW, window);
        write_reg(REG_WARN_RATE, warn);
        write_reg(REG_ERROR_RATE, err);
        write_reg(REG_HOLD_ERROR, hold_err);
        write_reg(REG_HOLD_WARN, hold_warn);
        settings_used++;
    endtask

    // Offers one tick transaction and returns at the falling edge after it is taken.
    task automatic send_tick(input logic [TIME_W-1:0] now_us, input logic [COUNT_W-1:0] total);
        int unsigned gap;
        gap = pick_gap(gaps_enabled);
        if (gap != 0)
        begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid       = 1'b1;
        tick_ch.now_time_us = now_us;
        tick_ch.event_total = total;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Random tick: mostly a full window with a count step aimed at a sticky rate band,
    // the rest quiet ticks, time jumps, time or count running backwards.
    task automatic send_random_tick();
        int unsigned        roll;
        logic [TIME_W-1:0]  step;
        logic [63:0]        lo_thr;
        logic [63:0]        hi_thr;
        logic [63:0]        target;
        logic [127:0]       scaled;
        logic [COUNT_W-1:0] delta;

        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
            rate_band = $urandom_range(0, 2);

        if (roll < 70)
        begin
            step = TIME_W'(reg_shadow[REG_WINDOW]);
            if ($urandom_range(0, 1) == 1)
                step = step + TIME_W'($urandom_range(0, reg_shadow[REG_WINDOW]));
            lo_thr = (reg_shadow[REG_WARN_RATE] < reg_shadow[REG_ERROR_RATE]) ?
                     64'(reg_shadow[REG_WARN_RATE]) : 64'(reg_shadow[REG_ERROR_RATE]);
            hi_thr = (reg_shadow[REG_WARN_RATE] < reg_shadow[REG_ERROR_RATE]) ?
                     64'(reg_shadow[REG_ERROR_RATE]) : 64'(reg_shadow[REG_WARN_RATE]);
            case (rate_band)
                0:
                    target = (lo_thr == 0) ? 64'd0 :
                             64'($urandom_range(0, 32'(lo_thr - 1)));
                1:
                    target = (hi_thr > lo_thr) ?
                             64'($urandom_range(32'(lo_thr), 32'(hi_thr - 1))) : lo_thr;
                default:
                    target = hi_thr + (hi_thr >> $urandom_range(1, 6))
                             + 64'($urandom_range(0, 3));
            endcase
            // Round the count step up so the measured rate lands at or above the target.
            scaled = (128'(target) * 128'(step) + 128'd999999) / 128'd1000000;
            delta  = (scaled > 128'hFFFF_FFFF) ? '1 : scaled[COUNT_W-1:0];
            tick_time  = tick_time + step;
            tick_count = tick_count + delta;
        end
        else if (roll < 85)
        begin
            tick_time  = tick_time + TIME_W'($urandom_range(0, reg_shadow[REG_WINDOW] - 1));
            tick_count = tick_count + COUNT_W'($urandom_range(0, 3));
        end
        else if (roll < 91)
        begin
            tick_time[47:32] = 16'($urandom);
            tick_time[31:0]  = $urandom;
            tick_count       = $urandom;
        end
        else if (roll < 95)
        begin
            tick_time  = tick_time - TIME_W'($urandom_range(1, 1000));
            tick_count = tick_count + COUNT_W'($urandom_range(0, 50));
        end
        else
        begin
            tick_time  = tick_time + TIME_W'(reg_shadow[REG_WINDOW]);
            tick_count = tick_count - COUNT_W'($urandom_range(1, 100000));
        end
        send_tick(tick_time, tick_count);
    endtask

    // Alert receiver: random stalls, stretches without any, and one long hold-off.
    initial
    begin
        int unsigned rx_cycles;
        int unsigned hold_left;
        int unsigned gap_left;
        rx_cycles      = 0;
        hold_left      = 0;
        gap_left       = 0;
        alert_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles == HOLD_OFF_AT)
                hold_left = HOLD_OFF_LEN;
            if (hold_left != 0)
            begin
                alert_ch.ready = 1'b0;
                hold_left--;
            end
            else if (rx_cycles % 2000 < 500)
                alert_ch.ready = 1'b1;
            else if (gap_left != 0)
            begin
                alert_ch.ready = 1'b0;
                gap_left--;
            end
            else
            begin
                alert_ch.ready = 1'b1;
                gap_left       = pick_gap(1'b1);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned drain_cycles;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_WINDOW;
        cfg_data            = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.now_time_us = '0;
        tick_ch.event_total = '0;
        reg_shadow[REG_WINDOW]     = WINDOW_RST;
        reg_shadow[REG_WARN_RATE]  = WARN_RATE_RST;
        reg_shadow[REG_ERROR_RATE] = ERROR_RATE_RST;
        reg_shadow[REG_HOLD_ERROR] = HOLD_ERROR_RST;
        reg_shadow[REG_HOLD_WARN]  = HOLD_WARN_RST;
        ticks_sent    = 0;
        settings_used = 1;
        rate_band     = 0;
        gaps_enabled  = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: window not elapsed, rise to warning, rise to error,
        // hold not yet met, straight drop to normal after the error hold.
        send_tick(48'd500000, 32'd3);
        send_tick(48'd1000000, 32'd8);
        send_tick(48'd2000000, 32'd20);
        send_tick(48'd3000000, 32'd250);
        send_tick(48'd4000000, 32'd255);
        send_tick(48'd14000000, 32'd256);
        // Error again, then the info transaction on the drop to warning,
        // then a silent drop to normal once the warning hold has passed.
        send_tick(48'd15000000, 32'd456);
        send_tick(48'd26000000, 32'd1006);
        send_tick(48'd27000000, 32'd1006);
        send_tick(48'd60000000, 32'd1006);
        // Time wraps to zero with the count running backwards: the rise restarts
        // the hold clock at zero, which the next fall treats as not running.
        send_tick(48'd0, 32'd1005);
        send_tick(48'd1000000, 32'd1005);
        send_tick(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);

        // One-microsecond window, zero holds, warning threshold above the error threshold;
        // rates just under and just over the saturation point.
        apply_settings(32'd1, 32'd5000, 32'd3000, 32'd0, 32'd0);
        send_tick(48'd0, 32'hFFFF_FFFF);
        send_tick(48'd1000, 32'd3);
        send_tick(48'd2000, 32'd4);
        send_tick(48'd2001, 32'd3);
        send_tick(48'd2003, 32'd3);
        send_tick(48'd2004, 32'd4297);
        send_tick(48'd2005, 32'd4297);
        send_tick(48'd2006, 32'd8592);

        // Maximum window and holds, zero warning threshold: one short of the window,
        // then exactly the window, which also meets the error hold exactly.
        apply_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(48'd4294969300, 32'd9000);
        send_tick(48'd4294969301, 32'd8592);
        send_tick(48'd8589936596, 32'd8592);

        tick_time  = 48'd8589936596;
        tick_count = 32'd8592;

        // Random phases under a spread of register settings.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_settings(32'd1000, 32'd10000, 32'd100000, 32'd5000, 32'd8000);
                1: apply_settings(32'd1, 32'd300000, 32'd200000, 32'd0, 32'd0);
                2: apply_settings($urandom_range(1, 4000), $urandom_range(0, 500000),
                                  $urandom_range(0, 1000000), $urandom_range(0, 20000),
                                  $urandom_range(0, 20000));
                3: apply_settings(32'd500, 32'd0, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
                4: apply_settings(32'd2000, 32'hFFFF_FFFF, 32'd50000,
                                  32'd3000, 32'hFFFF_FFFF);
                default: apply_settings(32'd100, 32'd5000, 32'd5000, 32'd1000, 32'd1000);
            endcase
            gaps_enabled = (phase != 1);
            repeat (ITEMS_PER_PHASE) send_random_tick();
        end

        // Drain outstanding alerts, then allow for a final silent evaluation.
        tick_ch.valid = 1'b0;
        drain_cycles  = 0;
        while (alerts_awaited != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (80) @(negedge clk);

        $display("Run covered %0d tick transactions over %0d register settings.",
                 ticks_sent, settings_used);
        $display("Alerts compared: %0d, mismatches: %0d, alerts never seen: %0d.",
                 alerts_checked, mismatch_count, alerts_awaited);
        if (mismatch_count == 0 && alerts_awaited == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #30_000_000;
        $display("Timed out waiting for the block.");
        $display("== FAIL ==");
        $finish;
    end

endmodule
